@@ sv/amsc_pkg.sv @@
// Shared types and constants for the accelerometer magnitude step counter.
package amsc_pkg;

    // Raw sample and result widths.
    localparam int AXIS_W  = 16;
    localparam int SUM_W   = 2 * AXIS_W;
    localparam int MAG_W   = 16;
    localparam int COUNT_W = 7;
    localparam int LED_W   = 64;
    localparam int THR_W   = 16;

    // One multiplier bit and one root digit are handled per cycle.
    localparam int DIGITS  = AXIS_W;
    localparam int CNT_W   = $clog2(DIGITS);

    localparam logic [THR_W-1:0]   THRESHOLD_RESET = THR_W'(600);
    localparam logic [COUNT_W-1:0] STEP_WRAP       = COUNT_W'(64);

    typedef struct packed {
        logic signed [AXIS_W-1:0] accel_x;
        logic signed [AXIS_W-1:0] accel_y;
        logic signed [AXIS_W-1:0] accel_z;
    } t_in;

    typedef struct packed {
        logic               step_detected;
        logic [COUNT_W-1:0] step_count;
        logic [MAG_W-1:0]   magnitude;
        logic [LED_W-1:0]   led_map;
    } t_out;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_FINISH
    } t_state;

endpackage

@@ sv/accel_magnitude_step_counter.sv @@
// Top level of the accelerometer magnitude step counter.
// Each sample passes through the idle state that accepts it, shift-add squaring,
// the two-bit-per-cycle square root and an update state, which holds while the
// output register is full and stalled.
// The input stalls outside the idle state, so one sample is handled at a time.
// A new sample is taken while the previous result still waits in the output register.
// Reset (synchronous, active low) clears the count and previous magnitude and sets
// the threshold to 600.
module accel_magnitude_step_counter
    import amsc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in              i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out             o_out_data,
    input  logic             i_cfg_we,
    input  logic [THR_W-1:0] i_cfg_data
);

    localparam logic [CNT_W-1:0] LAST_DIGIT = CNT_W'(DIGITS - 1);

    // Control state.
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_out_valid;
    logic [THR_W-1:0]   r_threshold;
    logic [MAG_W-1:0]   r_prev_mag;
    logic [COUNT_W-1:0] r_total;

    // Datapath: serial multiplier operands, accumulator and root digit recurrence.
    logic [SUM_W-1:0]   r_mcand_x, r_mcand_y, r_mcand_z;
    logic [AXIS_W-1:0]  r_mplier_x, r_mplier_y, r_mplier_z;
    logic [SUM_W-1:0]   r_acc;
    logic [17:0]        r_rem;
    logic [MAG_W-1:0]   r_root;
    t_out               r_out;

    // Handshake and sequencing decodes.
    logic               in_accept;
    logic               out_take;
    logic               finish_load;

    // Absolute values; the most negative sample maps to 32768, which fits unsigned.
    logic [AXIS_W-1:0]  abs_x, abs_y, abs_z;

    // Per-cycle combinational results.
    logic [SUM_W-1:0]   part_sum;
    logic [18:0]        work_rem;
    logic [18:0]        trial;
    logic [18:0]        diff;
    logic               root_ge;
    logic [MAG_W:0]     rise;
    logic               step;
    logic [COUNT_W-1:0] n_total;
    logic [LED_W-1:0]   led;

    assign abs_x = i_in_data.accel_x[AXIS_W-1] ? (~i_in_data.accel_x + 1'b1)
                                                : i_in_data.accel_x;
    assign abs_y = i_in_data.accel_y[AXIS_W-1] ? (~i_in_data.accel_y + 1'b1)
                                                : i_in_data.accel_y;
    assign abs_z = i_in_data.accel_z[AXIS_W-1] ? (~i_in_data.accel_z + 1'b1)
                                                : i_in_data.accel_z;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_SQUARE;
            end
            ST_SQUARE: begin
                if (r_cnt == LAST_DIGIT) n_state = ST_ROOT;
            end
            ST_ROOT: begin
                if (r_cnt == LAST_DIGIT) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (!r_out_valid || !i_out_stall) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        o_in_stall  = 1'b1;
        finish_load = 1'b0;
        unique case (r_state)
            ST_IDLE:   o_in_stall  = 1'b0;
            ST_SQUARE: o_in_stall  = 1'b1;
            ST_ROOT:   o_in_stall  = 1'b1;
            ST_FINISH: finish_load = !r_out_valid || !i_out_stall;
            default:   o_in_stall  = 1'b1;
        endcase
    end

    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_take    = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // One multiplier bit of each axis per cycle; the partial sums never exceed the
    // final sum of squares, so the 32-bit accumulator cannot overflow.
    assign part_sum = r_acc
                    + (r_mplier_x[0] ? r_mcand_x : '0)
                    + (r_mplier_y[0] ? r_mcand_y : '0)
                    + (r_mplier_z[0] ? r_mcand_z : '0);

    // Restoring square root: bring down two radicand bits and try 4q+1.
    assign work_rem = {r_rem[16:0], r_acc[SUM_W-1 -: 2]};
    assign trial    = {1'b0, r_root, 2'b01};
    assign diff     = work_rem - trial;
    assign root_ge  = (work_rem >= trial);

    // Step decision on the finished magnitude.
    assign rise = {1'b0, r_root} - {1'b0, r_prev_mag};
    assign step = (r_root > r_prev_mag) && (rise > {1'b0, r_threshold});

    always_comb begin
        n_total = r_total;
        if (step) begin
            n_total = (r_total == STEP_WRAP) ? '0 : r_total + 1'b1;
        end
    end

    // Bar map: LED k is lit when k+1 is below the new count.
    always_comb begin
        for (int k = 0; k < LED_W; k++) begin
            led[k] = (COUNT_W'(k + 1) < n_total);
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_threshold <= THRESHOLD_RESET;
            r_prev_mag  <= '0;
            r_total     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_threshold <= i_cfg_data;
            if (r_state == ST_SQUARE || r_state == ST_ROOT) begin
                r_cnt <= r_cnt + 1'b1;
            end else begin
                r_cnt <= '0;
            end
            if (finish_load) begin
                r_out_valid <= 1'b1;
                r_prev_mag  <= r_root;
                r_total     <= n_total;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mcand_x  <= SUM_W'(abs_x);
            r_mcand_y  <= SUM_W'(abs_y);
            r_mcand_z  <= SUM_W'(abs_z);
            r_mplier_x <= abs_x;
            r_mplier_y <= abs_y;
            r_mplier_z <= abs_z;
            r_acc      <= '0;
            r_rem      <= '0;
            r_root     <= '0;
        end else if (r_state == ST_SQUARE) begin
            r_mcand_x  <= r_mcand_x << 1;
            r_mcand_y  <= r_mcand_y << 1;
            r_mcand_z  <= r_mcand_z << 1;
            r_mplier_x <= r_mplier_x >> 1;
            r_mplier_y <= r_mplier_y >> 1;
            r_mplier_z <= r_mplier_z >> 1;
            r_acc      <= part_sum;
        end else if (r_state == ST_ROOT) begin
            r_acc  <= r_acc << 2;
            r_rem  <= root_ge ? diff[17:0] : work_rem[17:0];
            r_root <= {r_root[MAG_W-2:0], root_ge};
        end
        if (finish_load) begin
            r_out.step_detected <= step;
            r_out.step_count    <= n_total;
            r_out.magnitude     <= r_root;
            r_out.led_map       <= led;
        end
    end

`ifndef SYNTHESIS
    // The running count stays within its wrap range.
    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= STEP_WRAP)
        else $error("step count beyond wrap limit");

    // An accepted sample always starts the squaring phase.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == ST_SQUARE) && (r_cnt == '0))
        else $error("accepted sample did not start squaring");

    // Finishing a sample always presents a result.
    a_finish_presents: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish_load |=> o_out_valid && (r_state == ST_IDLE))
        else $error("finished sample not presented");

    // The bar map lights one LED fewer than a nonzero count, and none for a zero count.
    a_led_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($countones(o_out_data.led_map) ==
            ((o_out_data.step_count == '0) ? 0 : int'(o_out_data.step_count) - 1)))
        else $error("LED map does not match step count");
`endif

endmodule
